FILE: hdl/general_purpose_timer_regs_macros.svh
// ----------------------------------------------------------------------------
// General purpose timer assertion macros
// Shorthand for the concurrent checks used in the timer register block.
// ----------------------------------------------------------------------------
`ifndef GENERAL_PURPOSE_TIMER_REGS_MACROS_SVH
`define GENERAL_PURPOSE_TIMER_REGS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GPT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/gpt_pkg.sv
// ----------------------------------------------------------------------------
// General purpose timer package
// Item kinds, register offsets and the beat payload types of both channels.
// ----------------------------------------------------------------------------
package gpt_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_WRITE  = 2'd2,
      FUNC_STROBE = 2'd3
   } func_type;

   localparam logic [11:0] OFF_CFG      = 12'h000;
   localparam logic [11:0] OFF_TAMR     = 12'h004;
   localparam logic [11:0] OFF_TBMR     = 12'h008;
   localparam logic [11:0] OFF_CTL      = 12'h00C;
   localparam logic [11:0] OFF_IMR      = 12'h018;
   localparam logic [11:0] OFF_RIS      = 12'h01C;
   localparam logic [11:0] OFF_MIS      = 12'h020;
   localparam logic [11:0] OFF_CR       = 12'h024;
   localparam logic [11:0] OFF_TAILR    = 12'h028;
   localparam logic [11:0] OFF_TBILR    = 12'h02C;
   localparam logic [11:0] OFF_TAMATCHR = 12'h030;
   localparam logic [11:0] OFF_TBMATCHR = 12'h034;
   localparam logic [11:0] OFF_TAPR     = 12'h038;
   localparam logic [11:0] OFF_TBPR     = 12'h03C;
   localparam logic [11:0] OFF_TAPMR    = 12'h040;
   localparam logic [11:0] OFF_TBPMR    = 12'h044;
   localparam logic [11:0] OFF_TAR      = 12'h048;

   localparam logic [31:0] CFG_COUNTDOWN = 32'd0;
   localparam logic [31:0] CFG_RTC       = 32'd1;
   localparam logic [31:0] CFG_NARROW    = 32'd4;

   localparam logic [6:0] IMR_WRITE_MASK = 7'h77;

   localparam int CTL_ENABLE_BIT  = 0;
   localparam int CTL_TRIGGER_BIT = 5;
   localparam int RIS_TIMEOUT_BIT = 0;
   localparam int RIS_RTC_BIT     = 3;

   typedef struct packed {
      func_type    func;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        trigger_pulse;
   } rsp_type;

endpackage

FILE: hdl/gpt_chan_if.sv
// ----------------------------------------------------------------------------
// General purpose timer stream channel
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface gpt_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/general_purpose_timer_regs.sv
// ----------------------------------------------------------------------------
// General purpose timer register block
// Register file, 32-bit countdown timer and 32-bit real-time counter.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req_if    in          func, reg_offset, write_data
//   rsp_if    out         read_data, irq_level, trigger_pulse
//
// One item per cycle is accepted while the result side keeps taking beats,
// as all of its work is one pass of logic. A request beat loads the input
// register; it moves on to the result register, which offers the result beat.
// Synchronous reset clears every timer register and both stage valid flags.
// A stalled result holds the result register; the input register still takes
// one more beat, and only then is req_if.ready dropped.
// ----------------------------------------------------------------------------
`include "general_purpose_timer_regs_macros.svh"

module general_purpose_timer_regs (
   input  logic        clock,
   input  logic        reset,
   gpt_chan_if.sink    req_if,
   gpt_chan_if.source  rsp_if
);

   // Pipeline control and payload registers
   logic             in_valid_ff;
   gpt_pkg::req_type item_ff;
   logic             out_valid_ff;
   gpt_pkg::rsp_type result_ff;
   gpt_pkg::rsp_type result_in;

   // Timer state
   logic [31:0] cfg_ff,       cfg_in;
   logic [31:0] tamr_ff,      tamr_in;
   logic [31:0] tbmr_ff,      tbmr_in;
   logic [31:0] ctl_ff,       ctl_in;
   logic [3:0]  ris_ff,       ris_in;
   logic [6:0]  imr_ff,       imr_in;
   logic [15:0] load_lo_ff,   load_lo_in;
   logic [15:0] load_hi_ff,   load_hi_in;
   logic [15:0] match_lo_ff,  match_lo_in;
   logic [15:0] match_hi_ff,  match_hi_in;
   logic [31:0] tapr_ff,      tapr_in;
   logic [31:0] tbpr_ff,      tbpr_in;
   logic [31:0] tapmr_ff,     tapmr_in;
   logic [31:0] tbpmr_ff,     tbpmr_in;
   logic [31:0] rtc_ff,       rtc_in;
   logic [31:0] remain_ff,    remain_in;

   logic        advance;
   logic        fire;
   logic        wide;
   logic [31:0] full_load;
   logic [31:0] full_match;
   logic [31:0] rtc_next;
   logic [31:0] wdata;
   logic [31:0] rd;
   logic        trig;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign fire    = in_valid_ff && advance;

   assign req_if.ready   = !in_valid_ff || advance;
   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = result_ff;

   assign wide       = cfg_ff < gpt_pkg::CFG_NARROW;
   assign full_load  = {load_hi_ff, load_lo_ff};
   assign full_match = {match_hi_ff, match_lo_ff};
   assign wdata      = item_ff.write_data;
   assign rtc_next   = rtc_ff + 32'd1;

   // Register read mux
   always_comb begin
      case (item_ff.reg_offset)
         gpt_pkg::OFF_CFG:      rd = cfg_ff;
         gpt_pkg::OFF_TAMR:     rd = tamr_ff;
         gpt_pkg::OFF_TBMR:     rd = tbmr_ff;
         gpt_pkg::OFF_CTL:      rd = ctl_ff;
         gpt_pkg::OFF_IMR:      rd = {25'd0, imr_ff};
         gpt_pkg::OFF_RIS:      rd = {28'd0, ris_ff};
         gpt_pkg::OFF_MIS:      rd = {28'd0, ris_ff & imr_ff[3:0]};
         gpt_pkg::OFF_TAILR:    rd = wide ? full_load : {16'd0, load_lo_ff};
         gpt_pkg::OFF_TBILR:    rd = {16'd0, load_hi_ff};
         gpt_pkg::OFF_TAMATCHR: rd = wide ? full_match : {16'd0, match_lo_ff};
         gpt_pkg::OFF_TBMATCHR: rd = {16'd0, match_hi_ff};
         gpt_pkg::OFF_TAPR:     rd = tapr_ff;
         gpt_pkg::OFF_TBPR:     rd = tbpr_ff;
         gpt_pkg::OFF_TAPMR:    rd = tapmr_ff;
         gpt_pkg::OFF_TBPMR:    rd = tbpmr_ff;
         gpt_pkg::OFF_TAR:      rd = (cfg_ff == gpt_pkg::CFG_RTC) ? rtc_ff : 32'd0;
         default:               rd = 32'd0;
      endcase
   end

   // Next state of the timer for the item held in the input register
   always_comb begin
      cfg_in      = cfg_ff;
      tamr_in     = tamr_ff;
      tbmr_in     = tbmr_ff;
      ctl_in      = ctl_ff;
      ris_in      = ris_ff;
      imr_in      = imr_ff;
      load_lo_in  = load_lo_ff;
      load_hi_in  = load_hi_ff;
      match_lo_in = match_lo_ff;
      match_hi_in = match_hi_ff;
      tapr_in     = tapr_ff;
      tbpr_in     = tbpr_ff;
      tapmr_in    = tapmr_ff;
      tbpmr_in    = tbpmr_ff;
      rtc_in      = rtc_ff;
      remain_in   = remain_ff;
      trig        = 1'b0;

      case (item_ff.func)
         gpt_pkg::FUNC_TICK: begin
            if (cfg_ff == gpt_pkg::CFG_COUNTDOWN && ctl_ff[gpt_pkg::CTL_ENABLE_BIT]) begin
               if (remain_ff > 32'd1) begin
                  remain_in = remain_ff - 32'd1;
               end else begin
                  ris_in[gpt_pkg::RIS_TIMEOUT_BIT] = 1'b1;
                  trig = ctl_ff[gpt_pkg::CTL_TRIGGER_BIT];
                  // One-shot stops the timer; periodic reloads.
                  if (tamr_ff[0]) begin
                     ctl_in[gpt_pkg::CTL_ENABLE_BIT] = 1'b0;
                     remain_in = 32'd0;
                  end else begin
                     remain_in = full_load;
                  end
               end
            end
         end
         gpt_pkg::FUNC_WRITE: begin
            case (item_ff.reg_offset)
               gpt_pkg::OFF_CFG:  cfg_in  = wdata;
               gpt_pkg::OFF_TAMR: tamr_in = wdata;
               gpt_pkg::OFF_TBMR: tbmr_in = wdata;
               gpt_pkg::OFF_CTL: begin
                  ctl_in = wdata;
                  // Arming edge of the enable bit loads the countdown.
                  if (!ctl_ff[gpt_pkg::CTL_ENABLE_BIT] && wdata[gpt_pkg::CTL_ENABLE_BIT]
                      && cfg_ff == gpt_pkg::CFG_COUNTDOWN) begin
                     remain_in = full_load;
                  end
               end
               gpt_pkg::OFF_IMR: imr_in = wdata[6:0] & gpt_pkg::IMR_WRITE_MASK;
               gpt_pkg::OFF_CR:  ris_in = ris_ff & ~wdata[3:0];
               gpt_pkg::OFF_TAILR: begin
                  load_lo_in = wdata[15:0];
                  if (wide) begin
                     load_hi_in = wdata[31:16];
                  end
               end
               gpt_pkg::OFF_TBILR: load_hi_in = wdata[15:0];
               gpt_pkg::OFF_TAMATCHR: begin
                  match_lo_in = wdata[15:0];
                  if (wide) begin
                     match_hi_in = wdata[31:16];
                  end
               end
               gpt_pkg::OFF_TBMATCHR: match_hi_in = wdata[15:0];
               gpt_pkg::OFF_TAPR:     tapr_in     = wdata;
               gpt_pkg::OFF_TBPR:     tbpr_in     = wdata;
               gpt_pkg::OFF_TAPMR:    tapmr_in    = wdata;
               gpt_pkg::OFF_TBPMR:    tbpmr_in    = wdata;
               default: begin
               end
            endcase
         end
         gpt_pkg::FUNC_STROBE: begin
            if (cfg_ff == gpt_pkg::CFG_RTC && ctl_ff[gpt_pkg::CTL_ENABLE_BIT]) begin
               // Past the match value the count wraps to zero.
               if (rtc_next > full_match || rtc_next == 32'd0) begin
                  rtc_in = 32'd0;
                  ris_in[gpt_pkg::RIS_RTC_BIT] = 1'b1;
               end else begin
                  rtc_in = rtc_next;
               end
            end
         end
         default: begin
         end
      endcase

      result_in.read_data     = (item_ff.func == gpt_pkg::FUNC_READ) ? rd : 32'd0;
      result_in.irq_level     = |(ris_in & imr_in[3:0]);
      result_in.trigger_pulse = trig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
         tamr_ff      <= '0;
         tbmr_ff      <= '0;
         ctl_ff       <= '0;
         ris_ff       <= '0;
         imr_ff       <= '0;
         load_lo_ff   <= '0;
         load_hi_ff   <= '0;
         match_lo_ff  <= '0;
         match_hi_ff  <= '0;
         tapr_ff      <= '0;
         tbpr_ff      <= '0;
         tapmr_ff     <= '0;
         tbpmr_ff     <= '0;
         rtc_ff       <= '0;
         remain_ff    <= '0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            cfg_ff      <= cfg_in;
            tamr_ff     <= tamr_in;
            tbmr_ff     <= tbmr_in;
            ctl_ff      <= ctl_in;
            ris_ff      <= ris_in;
            imr_ff      <= imr_in;
            load_lo_ff  <= load_lo_in;
            load_hi_ff  <= load_hi_in;
            match_lo_ff <= match_lo_in;
            match_hi_ff <= match_hi_in;
            tapr_ff     <= tapr_in;
            tbpr_ff     <= tbpr_in;
            tapmr_ff    <= tapmr_in;
            tbpmr_ff    <= tbpmr_in;
            rtc_ff      <= rtc_in;
            remain_ff   <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         item_ff <= req_if.payload;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   // The interrupt level in a waiting result matches the live status.
   `GPT_ASSERT_IMPLY(a_irq_matches_state, clock, reset, out_valid_ff, result_ff.irq_level == (|(ris_ff & imr_ff[3:0])), "irq level disagrees with masked status")

   // A trigger pulse only leaves with the timeout status bit set.
   `GPT_ASSERT_IMPLY(a_trigger_sets_status, clock, reset, out_valid_ff && result_ff.trigger_pulse, ris_ff[gpt_pkg::RIS_TIMEOUT_BIT], "trigger without timeout status")

   // Backpressure reaches the request side only with both stages full.
   `GPT_ASSERT_IMPLY(a_ready_low_when_full, clock, reset, !req_if.ready, in_valid_ff && out_valid_ff && !rsp_if.ready, "request stalled without a full pipeline")

   // An item in the input register reaches the result register once it may advance.
   `GPT_ASSERT_NEXT(a_fire_fills_result, clock, reset, fire, out_valid_ff, "processed item lost")

endmodule

FILE: test/tb_general_purpose_timer_regs.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer register block testbench
// Drives ticks, strobes and register accesses through the request channel and
// checks every result beat against a cycle-free model of the timer, under
// several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_general_purpose_timer_regs;
   import gpt_pkg::*;

   localparam logic [11:0] OFF_TBR     = 12'h04C;
   localparam logic [11:0] OFF_UNUSED  = 12'h010;
   localparam int          TAMR_ONE_SHOT_BIT = 0;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          DRAIN_CYCLES = 8;

   // Tracks the timer state and the results still owed by the block.
   class timer_scoreboard;
      logic [31:0] cfg, tamr, tbmr, ctl;
      logic [31:0] tapr, tbpr, tapmr, tbpmr;
      logic [31:0] rtc_count, ticks_left;
      logic [3:0]  ris;
      logic [6:0]  imr;
      logic [15:0] load_lo, load_hi, match_lo, match_hi;
      rsp_type     owed_beats[$];
      int          mismatches;

      function new();
         cfg = '0;
         tamr = '0;
         tbmr = '0;
         ctl = '0;
         tapr = '0;
         tbpr = '0;
         tapmr = '0;
         tbpmr = '0;
         rtc_count = '0;
         ticks_left = '0;
         ris = '0;
         imr = '0;
         load_lo = '0;
         load_hi = '0;
         match_lo = '0;
         match_hi = '0;
         mismatches = 0;
      endfunction

      function logic [31:0] read_reg(logic [11:0] off);
         logic wide;
         wide = (cfg < CFG_NARROW);
         case (off)
            OFF_CFG:      return cfg;
            OFF_TAMR:     return tamr;
            OFF_TBMR:     return tbmr;
            OFF_CTL:      return ctl;
            OFF_IMR:      return {25'b0, imr};
            OFF_RIS:      return {28'b0, ris};
            OFF_MIS:      return {28'b0, ris & imr[3:0]};
            OFF_TAILR:    return wide ? {load_hi, load_lo} : {16'b0, load_lo};
            OFF_TBILR:    return {16'b0, load_hi};
            OFF_TAMATCHR: return wide ? {match_hi, match_lo} : {16'b0, match_lo};
            OFF_TBMATCHR: return {16'b0, match_hi};
            OFF_TAPR:     return tapr;
            OFF_TBPR:     return tbpr;
            OFF_TAPMR:    return tapmr;
            OFF_TBPMR:    return tbpmr;
            OFF_TAR:      return (cfg == CFG_RTC) ? rtc_count : 32'b0;
            default:      return 32'b0;
         endcase
      endfunction

      function void write_reg(logic [11:0] off, logic [31:0] v);
         logic wide;
         wide = (cfg < CFG_NARROW);
         case (off)
            OFF_CFG:  cfg = v;
            OFF_TAMR: tamr = v;
            OFF_TBMR: tbmr = v;
            OFF_CTL: begin
               // Only a rising enable in countdown mode reloads the counter.
               if (!ctl[CTL_ENABLE_BIT] && v[CTL_ENABLE_BIT] && cfg == CFG_COUNTDOWN)
                  ticks_left = {load_hi, load_lo};
               ctl = v;
            end
            OFF_IMR: imr = v[6:0] & IMR_WRITE_MASK;
            OFF_CR:  ris = ris & ~v[3:0];
            OFF_TAILR: begin
               load_lo = v[15:0];
               if (wide)
                  load_hi = v[31:16];
            end
            OFF_TBILR: load_hi = v[15:0];
            OFF_TAMATCHR: begin
               match_lo = v[15:0];
               if (wide)
                  match_hi = v[31:16];
            end
            OFF_TBMATCHR: match_hi = v[15:0];
            OFF_TAPR:  tapr = v;
            OFF_TBPR:  tbpr = v;
            OFF_TAPMR: tapmr = v;
            OFF_TBPMR: tbpmr = v;
            default: ;
         endcase
      endfunction

      function logic count_tick();
         logic pulse;
         pulse = 1'b0;
         if (cfg != CFG_COUNTDOWN || !ctl[CTL_ENABLE_BIT])
            return 1'b0;
         if (ticks_left > 32'd1) begin
            ticks_left = ticks_left - 32'd1;
            return 1'b0;
         end
         ris[RIS_TIMEOUT_BIT] = 1'b1;
         pulse = ctl[CTL_TRIGGER_BIT];
         if (tamr[TAMR_ONE_SHOT_BIT]) begin
            ctl[CTL_ENABLE_BIT] = 1'b0;
            ticks_left = '0;
         end else begin
            ticks_left = {load_hi, load_lo};
         end
         return pulse;
      endfunction

      function void count_second();
         if (cfg != CFG_RTC || !ctl[CTL_ENABLE_BIT])
            return;
         rtc_count = rtc_count + 32'd1;
         if (rtc_count > {match_hi, match_lo})
            rtc_count = '0;
         if (rtc_count == '0)
            ris[RIS_RTC_BIT] = 1'b1;
      endfunction

      function void note_request(req_type item);
         rsp_type owed;
         owed = '0;
         case (item.func)
            FUNC_TICK:  owed.trigger_pulse = count_tick();
            FUNC_READ:  owed.read_data = read_reg(item.reg_offset);
            FUNC_WRITE: write_reg(item.reg_offset, item.write_data);
            default:    count_second();
         endcase
         owed.irq_level = (({3'b0, ris} & imr) != 7'b0);
         owed_beats.push_back(owed);
      endfunction

      task report_mismatch(string text);
         $display("MISMATCH at %0t: %s", $realtime, text);
         mismatches++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (owed_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %h", got));
            return;
         end
         want = owed_beats.pop_front();
         if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
               got.read_data, want.read_data));
         if (got.irq_level !== want.irq_level)
            report_mismatch($sformatf("irq_level %b, expected %b",
               got.irq_level, want.irq_level));
         if (got.trigger_pulse !== want.trigger_pulse)
            report_mismatch($sformatf("trigger_pulse %b, expected %b",
               got.trigger_pulse, want.trigger_pulse));
      endtask
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   hold_request;
   int   hold_left;
   int   quiet_cycles;

   gpt_chan_if #(.payload_type(req_type)) req_if ();
   gpt_chan_if #(.payload_type(rsp_type)) rsp_if ();

   timer_scoreboard timer_sb = new();

   general_purpose_timer_regs dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         timer_sb.note_request(req_if.payload);
      if (!reset && rsp_if.valid && rsp_if.ready)
         timer_sb.check_result(rsp_if.payload);
   end

   // The run ends as a failure when no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Sink side: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_if.ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task send_beat(req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task send_op(func_type f, logic [11:0] off, logic [31:0] data);
      req_type item;
      item.func = f;
      item.reg_offset = off;
      item.write_data = data;
      send_beat(item);
   endtask

   // Lowers valid and waits until every owed result has arrived.
   task drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (timer_sb.owed_beats.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [11:0] pick_offset();
      case ($urandom_range(18))
         0:  return OFF_CFG;
         1:  return OFF_TAMR;
         2:  return OFF_TBMR;
         3:  return OFF_CTL;
         4:  return OFF_IMR;
         5:  return OFF_RIS;
         6:  return OFF_MIS;
         7:  return OFF_CR;
         8:  return OFF_TAILR;
         9:  return OFF_TBILR;
         10: return OFF_TAMATCHR;
         11: return OFF_TBMATCHR;
         12: return OFF_TAPR;
         13: return OFF_TBPR;
         14: return OFF_TAPMR;
         15: return OFF_TBPMR;
         16: return OFF_TAR;
         17: return OFF_TBR;
         default: return OFF_UNUSED;
      endcase
   endfunction

   // Mostly counting traffic with small load and match values, so that
   // expiries and RTC wraps happen often; the rest is full-range noise.
   function automatic req_type random_item();
      req_type     item;
      int          roll;
      logic [31:0] bits;
      bits = $urandom;
      item.write_data = $urandom;
      roll = $urandom_range(99);
      if (roll < 35)
         item.func = FUNC_TICK;
      else if (roll < 55)
         item.func = FUNC_STROBE;
      else if (roll < 75)
         item.func = FUNC_READ;
      else
         item.func = FUNC_WRITE;
      item.reg_offset = ($urandom_range(99) < 88) ? pick_offset() : bits[11:0];
      if (item.func == FUNC_WRITE) begin
         roll = $urandom_range(99);
         case (item.reg_offset)
            OFF_CFG:
               if (roll < 45)
                  item.write_data = CFG_COUNTDOWN;
               else if (roll < 90)
                  item.write_data = CFG_RTC;
               else if (roll < 96)
                  item.write_data = $urandom_range(2, 7);
            OFF_CTL:
               item.write_data[CTL_ENABLE_BIT] = (roll < 70);
            OFF_TAILR, OFF_TAMATCHR:
               if (roll < 85)
                  item.write_data = $urandom_range(0, 6);
            OFF_TBILR, OFF_TBMATCHR:
               if (roll < 85)
                  item.write_data = '0;
            default: ;
         endcase
      end
      return item;
   endfunction

   task run_phase(int idle, int stall, int count);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count)
         send_beat(random_item());
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 0;
      quiet_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Countdown: full-width load, zero load, periodic then one-shot expiry.
      send_op(FUNC_WRITE, OFF_TAILR, 32'hFFFF_FFFF);
      send_op(FUNC_READ, OFF_TAILR, 32'h0);
      send_op(FUNC_WRITE, OFF_TAILR, 32'h0);
      send_op(FUNC_WRITE, OFF_IMR, 32'hFFFF_FFFF);
      send_op(FUNC_WRITE, OFF_CTL, 32'h21);
      send_op(FUNC_TICK, 12'h000, 32'h0);
      send_op(FUNC_READ, OFF_MIS, 32'h0);
      send_op(FUNC_WRITE, OFF_CR, 32'hFFFF_FFFF);
      send_op(FUNC_WRITE, OFF_TAILR, 32'h1);
      send_op(FUNC_WRITE, OFF_TAMR, 32'h1);
      send_op(FUNC_TICK, 12'h000, 32'h0);
      send_op(FUNC_TICK, 12'hFFF, 32'hFFFF_FFFF);
      send_op(FUNC_STROBE, 12'h000, 32'h0);
      // RTC: wrong item kind, wrap past the match value, ignored TAR write.
      send_op(FUNC_WRITE, OFF_CFG, CFG_RTC);
      send_op(FUNC_TICK, 12'h000, 32'h0);
      send_op(FUNC_WRITE, OFF_TAMATCHR, 32'h1);
      send_op(FUNC_WRITE, OFF_CTL, 32'h1);
      send_op(FUNC_STROBE, 12'h000, 32'h0);
      send_op(FUNC_STROBE, 12'h000, 32'h0);
      send_op(FUNC_WRITE, OFF_TAR, 32'h1234_5678);
      send_op(FUNC_READ, OFF_TAR, 32'h0);
      // Narrow configuration, prescale match, bad and read-only offsets.
      send_op(FUNC_WRITE, OFF_CFG, 32'hFFFF_FFFF);
      send_op(FUNC_WRITE, OFF_TAMATCHR, 32'hA5A5_FFFF);
      send_op(FUNC_READ, OFF_TAMATCHR, 32'h0);
      send_op(FUNC_WRITE, OFF_TBPMR, 32'hFFFF_FFFF);
      send_op(FUNC_READ, OFF_TBPMR, 32'h0);
      send_op(FUNC_READ, 12'hFFF, 32'h0);
      send_op(FUNC_WRITE, 12'h02A, 32'hFFFF_FFFF);
      send_op(FUNC_READ, OFF_TBR, 32'h0);
      send_op(FUNC_WRITE, OFF_CFG, CFG_COUNTDOWN);
      drain_results();

      run_phase(0, 0, 390);
      run_phase(84, 0, 390);
      run_phase(0, 84, 390);
      run_phase(11, 11, 390);

      // Long sink hold-off while the source keeps offering beats.
      stall_pct = 0;
      idle_pct = 0;
      hold_request = 80;
      repeat (30)
         send_beat(random_item());
      drain_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (timer_sb.mismatches == 0 && timer_sb.owed_beats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
